// ===== rtl/core/cpu8_pkg.sv =====
`default_nettype none
package cpu8_pkg;

  localparam int PROG_WORDS_DEF  = 2048;
  localparam int STACK_DEPTH_DEF = 16;
  localparam int NUM_PORTS_DEF   = 8;

  typedef logic [15:0] word_t;
  typedef logic [7:0]  byte_t;
  typedef logic [10:0] addr_t;
  typedef logic [2:0]  rsel_t;
  typedef logic [4:0]  flags_t;
  typedef logic [4:0]  opcode_t;

  // flag bit positions
  localparam int FLG_Z = 0;
  localparam int FLG_M = 1;
  localparam int FLG_L = 2;
  localparam int FLG_S = 3;
  localparam int FLG_H = 4;

  localparam opcode_t OP_NOP  = 5'd0;
  localparam opcode_t OP_HALT = 5'd1;
  localparam opcode_t OP_JMP  = 5'd2;
  localparam opcode_t OP_BR   = 5'd3;
  localparam opcode_t OP_CALL = 5'd4;
  localparam opcode_t OP_RET  = 5'd5;
  localparam opcode_t OP_LDI  = 5'd6;
  localparam opcode_t OP_MOV  = 5'd7;
  localparam opcode_t OP_ADD  = 5'd8;
  localparam opcode_t OP_SUB  = 5'd9;
  localparam opcode_t OP_ADDI = 5'd10;
  localparam opcode_t OP_ADDS = 5'd11;
  localparam opcode_t OP_XOR  = 5'd12;
  localparam opcode_t OP_AND  = 5'd13;
  localparam opcode_t OP_OR   = 5'd14;
  localparam opcode_t OP_CMP  = 5'd15;
  localparam opcode_t OP_XORI = 5'd16;
  localparam opcode_t OP_ANDI = 5'd17;
  localparam opcode_t OP_ORI  = 5'd18;
  localparam opcode_t OP_CMPI = 5'd19;
  localparam opcode_t OP_SHR  = 5'd20;
  localparam opcode_t OP_SHL  = 5'd21;
  localparam opcode_t OP_ROL  = 5'd22;
  localparam opcode_t OP_ASR  = 5'd23;
  localparam opcode_t OP_SHRI = 5'd24;
  localparam opcode_t OP_SHLI = 5'd25;
  localparam opcode_t OP_ROLI = 5'd26;
  localparam opcode_t OP_ASRI = 5'd27;
  localparam opcode_t OP_ST   = 5'd28;
  localparam opcode_t OP_LD   = 5'd29;
  localparam opcode_t OP_OUT  = 5'd30;
  localparam opcode_t OP_IN   = 5'd31;

  // branch conditions
  localparam rsel_t CC_Z    = 3'd0;
  localparam rsel_t CC_NZ   = 3'd1;
  localparam rsel_t CC_GT   = 3'd2;
  localparam rsel_t CC_MI   = 3'd3;
  localparam rsel_t CC_PL   = 3'd4;
  localparam rsel_t CC_LE   = 3'd5;
  localparam rsel_t CC_EVEN = 3'd6;
  localparam rsel_t CC_SOF  = 3'd7;

endpackage
`default_nettype wire

// ===== rtl/core/cpu8_if.sv =====
`default_nettype none
interface cpu8_in_if;
  import cpu8_pkg::*;

  logic  valid;
  logic  ready;
  word_t instr_word;
  byte_t port_in_data;
  logic  port_in_ok;
  byte_t rand_byte;

  modport source (output valid, instr_word, port_in_data, port_in_ok, rand_byte,
                  input ready);
  modport sink (input valid, instr_word, port_in_data, port_in_ok, rand_byte,
                output ready);
endinterface

interface cpu8_out_if;
  import cpu8_pkg::*;

  logic  valid;
  logic  ready;
  addr_t fetch_addr;
  logic  port_wr;
  logic  port_rd;
  rsel_t port_sel;
  byte_t port_out_data;
  logic  halted;

  modport source (output valid, fetch_addr, port_wr, port_rd, port_sel, port_out_data,
                  halted, input ready);
  modport sink (input valid, fetch_addr, port_wr, port_rd, port_sel, port_out_data,
                halted, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/eight_bit_cpu_instruction_step_core.sv =====
// An instruction taken into the execute stage register executes out of it, and its result
// transaction is offered from the result register once the instruction retires.
// Throughput: one instruction per cycle while the result register is free; write-back into the
// register file and data memory is forwarded straight into the operand fetch of the next instruction.
// Synchronous active-high reset clears registers, flags, counter, call stack, stack index
// and the data memory valid bits (unwritten memory reads as zero). No clearing pass.
`default_nettype none
module eight_bit_cpu_instruction_step_core #(
  parameter int PROG_WORDS  = cpu8_pkg::PROG_WORDS_DEF,
  parameter int STACK_DEPTH = cpu8_pkg::STACK_DEPTH_DEF,
  parameter int NUM_PORTS   = cpu8_pkg::NUM_PORTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  cpu8_in_if.sink    req,
  cpu8_out_if.source rsp
);
  import cpu8_pkg::*;

  localparam int            SW       = $clog2(STACK_DEPTH);
  localparam logic [SW-1:0] STK_LAST = SW'(STACK_DEPTH - 1);
  localparam logic [14:0]   PW       = 15'(PROG_WORDS);
  localparam logic [3:0]    NP       = 4'(NUM_PORTS);

  // architectural state
  byte_t         rf [8];
  flags_t        flags;
  addr_t         pc;
  addr_t         stk [STACK_DEPTH];
  logic [SW-1:0] sidx;
  byte_t         dmem [256];
  logic [255:0]  dvld;

  // execute stage register
  logic  iv;
  word_t iw;
  byte_t a_op, b_op, pdata, rnd;
  logic  pok;
  byte_t dm_q;
  logic  dv_q, byp_q;
  byte_t byp_d;

  // result register
  logic  ov;
  addr_t fetch_addr;
  logic  port_wr, port_rd;
  rsel_t port_sel;
  byte_t port_out_data;
  logic  halted;

  logic out_free, retire, accept;

  assign out_free  = !ov || rsp.ready;
  assign retire    = iv && out_free;
  assign req.ready = !iv || retire;
  assign accept    = req.valid && req.ready;

  // decode
  opcode_t op;
  rsel_t   ra, rc, rb, amt, neg_amt;
  byte_t   imm8, ld_val, sum_b, cmp_b, diff;
  byte_t   shr_res, shl_res, rol_res, asr_res;
  logic    cond;

  assign op      = iw[15:11];
  assign ra      = iw[10:8];
  assign rc      = iw[7:5];
  assign rb      = iw[2:0];
  assign imm8    = iw[7:0];
  assign ld_val  = byp_q ? byp_d : (dv_q ? dm_q : 8'h00);
  assign amt     = (op >= OP_SHRI) ? rb : b_op[2:0];
  assign neg_amt = ~amt + 3'd1;
  assign shr_res = a_op >> neg_amt;
  assign shl_res = a_op << amt;
  assign rol_res = (a_op << amt) | (a_op >> (4'd8 - {1'b0, amt}));
  assign asr_res = byte_t'($signed(a_op) >>> amt);
  assign cmp_b   = (op == OP_CMPI) ? imm8 : b_op;
  assign diff    = a_op - cmp_b;
  assign sum_b   = (op == OP_ADDS) ? {{3{iw[4]}}, iw[4:0]} : b_op;

  always_comb begin
    unique case (ra)
      CC_Z:    cond = flags[FLG_Z];
      CC_NZ:   cond = !flags[FLG_Z];
      CC_GT:   cond = !(flags[FLG_Z] || flags[FLG_M]);
      CC_MI:   cond = flags[FLG_M];
      CC_PL:   cond = !flags[FLG_M];
      CC_LE:   cond = flags[FLG_Z] || flags[FLG_M];
      CC_EVEN: cond = !flags[FLG_L];
      default: cond = flags[FLG_M] ^ flags[FLG_S];
    endcase
  end

  // execute
  logic          wb_req, wb_en, st_en, push, pop;
  rsel_t         wb_addr;
  byte_t         wb_data;
  flags_t        flags_next;
  addr_t         pc_t, pc_new;
  logic [SW-1:0] sidx_dec, sidx_inc, sidx_next;
  logic [14:0]   pc_inc, pc_m;
  logic          x_wr, x_rd, port_ok;
  rsel_t         x_sel;
  byte_t         x_pout;

  assign sidx_dec = (sidx == '0) ? STK_LAST : sidx - SW'(1);
  assign sidx_inc = (sidx == STK_LAST) ? '0 : sidx + SW'(1);
  assign port_ok  = {1'b0, rb} < NP;

  always_comb begin
    wb_req     = 1'b0;
    wb_addr    = ra;
    wb_data    = 8'h00;
    st_en      = 1'b0;
    push       = 1'b0;
    pop        = 1'b0;
    flags_next = flags;
    pc_t       = pc;
    x_wr       = 1'b0;
    x_rd       = 1'b0;
    x_sel      = '0;
    x_pout     = 8'h00;
    unique case (op)
      OP_NOP: ;
      OP_HALT: flags_next[FLG_H] = 1'b1;
      OP_JMP:  pc_t = iw[10:0];
      OP_BR: begin
        if (cond) pc_t = {pc[10:8], imm8};
      end
      OP_CALL: begin
        push = 1'b1;
        pc_t = iw[10:0];
      end
      OP_RET: begin
        pop  = 1'b1;
        pc_t = stk[sidx_dec];
      end
      OP_LDI: begin wb_req = 1'b1; wb_data = imm8; end
      OP_MOV: begin wb_req = 1'b1; wb_data = b_op; end
      OP_ADD, OP_ADDS: begin wb_req = 1'b1; wb_addr = rc; wb_data = a_op + sum_b; end
      OP_SUB:  begin wb_req = 1'b1; wb_addr = rc; wb_data = a_op - b_op; end
      OP_ADDI: begin wb_req = 1'b1; wb_data = a_op + imm8; end
      OP_XOR:  begin wb_req = 1'b1; wb_addr = rc; wb_data = a_op ^ b_op; end
      OP_AND:  begin wb_req = 1'b1; wb_addr = rc; wb_data = a_op & b_op; end
      OP_OR:   begin wb_req = 1'b1; wb_addr = rc; wb_data = a_op | b_op; end
      OP_CMP, OP_CMPI: begin
        flags_next[FLG_Z] = (diff == 8'h00);
        flags_next[FLG_M] = diff[7];
        flags_next[FLG_L] = diff[0];
        flags_next[FLG_S] = diff[6];
      end
      OP_XORI: begin wb_req = 1'b1; wb_data = a_op ^ imm8; end
      OP_ANDI: begin wb_req = 1'b1; wb_data = a_op & imm8; end
      OP_ORI:  begin wb_req = 1'b1; wb_data = a_op | imm8; end
      OP_SHR:  begin wb_req = 1'b1; wb_addr = rc; wb_data = shr_res; end
      OP_SHL:  begin wb_req = 1'b1; wb_addr = rc; wb_data = shl_res; end
      OP_ROL:  begin wb_req = 1'b1; wb_addr = rc; wb_data = rol_res; end
      OP_ASR:  begin wb_req = 1'b1; wb_addr = rc; wb_data = asr_res; end
      OP_SHRI: begin wb_req = 1'b1; wb_data = shr_res; end
      OP_SHLI: begin wb_req = 1'b1; wb_data = shl_res; end
      OP_ROLI: begin wb_req = 1'b1; wb_data = rol_res; end
      OP_ASRI: begin wb_req = 1'b1; wb_data = asr_res; end
      OP_ST:   st_en = 1'b1;
      OP_LD:   begin wb_req = 1'b1; wb_data = ld_val; end
      OP_OUT: begin
        x_sel = rb;
        if (port_ok) begin
          x_wr   = 1'b1;
          x_pout = a_op;
        end
      end
      OP_IN: begin
        x_sel = rb;
        if (iw[3]) begin
          wb_req  = 1'b1;
          wb_data = rnd;
        end else if (port_ok) begin
          x_rd    = 1'b1;
          wb_req  = pok;
          wb_data = pdata;
        end
      end
      default: ;
    endcase
  end

  assign wb_en     = wb_req && (wb_addr != '0);
  assign sidx_next = push ? sidx_inc : (pop ? sidx_dec : sidx);

  // counter wraps at the program size; multiples up to eight are compared in parallel and the
  // largest one that fits is taken off, exact while the quotient is at most eight (PROG_WORDS of 228 or more)
  always_comb begin
    pc_inc = {4'b0000, pc_t} + 15'd1;
    pc_m   = pc_inc;
    for (int k = 1; k <= 8; k++) begin
      if (pc_inc >= PW * 15'(k)) pc_m = pc_inc - PW * 15'(k);
    end
  end
  assign pc_new = pc_m[10:0];

  // operand fetch with forwarding from the retiring instruction
  rsel_t ra_in, rb_in;
  byte_t a_in, b_in;
  logic  fwd_ok;

  assign ra_in  = req.instr_word[10:8];
  assign rb_in  = req.instr_word[2:0];
  assign fwd_ok = retire && wb_en;
  assign a_in   = (fwd_ok && wb_addr == ra_in) ? wb_data : rf[ra_in];
  assign b_in   = (fwd_ok && wb_addr == rb_in) ? wb_data : rf[rb_in];

  always_ff @(posedge clk) begin
    if (rst) begin
      iv    <= 1'b0;
      ov    <= 1'b0;
      flags <= '0;
      pc    <= '0;
      sidx  <= '0;
      dvld  <= '0;
      for (int i = 0; i < 8; i++) rf[i] <= '0;
      for (int i = 0; i < STACK_DEPTH; i++) stk[i] <= '0;
    end else begin
      if (req.ready) iv <= req.valid;
      if (retire) ov <= 1'b1;
      else if (rsp.ready) ov <= 1'b0;
      if (retire) begin
        flags <= flags_next;
        pc    <= pc_new;
        sidx  <= sidx_next;
        if (push) stk[sidx] <= pc;
        if (wb_en) rf[wb_addr] <= wb_data;
        if (st_en) dvld[b_op] <= 1'b1;
      end
    end
  end

  // data memory; a store retiring as a load is taken is bypassed
  always_ff @(posedge clk) begin
    if (retire && st_en) dmem[b_op] <= a_op;
    if (accept) dm_q <= dmem[b_in];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      iw    <= req.instr_word;
      pdata <= req.port_in_data;
      pok   <= req.port_in_ok;
      rnd   <= req.rand_byte;
      a_op  <= a_in;
      b_op  <= b_in;
      dv_q  <= dvld[b_in];
      byp_q <= retire && st_en && (b_op == b_in);
      byp_d <= a_op;
    end
    if (retire) begin
      fetch_addr    <= pc_new;
      port_wr       <= x_wr;
      port_rd       <= x_rd;
      port_sel      <= x_sel;
      port_out_data <= x_pout;
      halted        <= flags_next[FLG_H];
    end
  end

  assign rsp.valid         = ov;
  assign rsp.fetch_addr    = fetch_addr;
  assign rsp.port_wr       = port_wr;
  assign rsp.port_rd       = port_rd;
  assign rsp.port_sel      = port_sel;
  assign rsp.port_out_data = port_out_data;
  assign rsp.halted        = halted;

endmodule
`default_nettype wire

// ===== rtl/core/cpu8_chk.sv =====
`default_nettype none
module cpu8_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [10:0] fetch_addr,
  input wire logic        port_wr,
  input wire logic        port_rd,
  input wire logic [7:0]  port_out_data,
  input wire logic        halted
);

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result transaction dropped while stalled");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(fetch_addr) && $stable(port_out_data))
    else $error("result payload changed while stalled");

  a_port_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(port_wr && port_rd))
    else $error("port read and write in one instruction");

  a_pout_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !port_wr |-> port_out_data == 8'h00)
    else $error("port data without a port write");

  // halt is sticky: while results are offered back to back, none may clear it
  a_halt_sticky: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |=> !out_valid || halted)
    else $error("halt flag cleared");

endmodule

bind eight_bit_cpu_instruction_step_core cpu8_chk u_cpu8_chk (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .fetch_addr    (rsp.fetch_addr),
  .port_wr       (rsp.port_wr),
  .port_rd       (rsp.port_rd),
  .port_out_data (rsp.port_out_data),
  .halted        (rsp.halted)
);
`default_nettype wire
